// ===== rtl/core/omre_pkg.sv =====
// Package for the ordered multiset rank engine: request and result structs,
// operation and status codes, default sizes. No dependencies.
package omre_pkg;

  localparam int unsigned DefCapacity  = 64;
  localparam int unsigned DefCountBits = 16;
  localparam int unsigned KeyW         = 32;
  localparam int unsigned TotW         = 22;

  typedef enum logic [3:0] {
    OP_INSERT = 4'd0,
    OP_DELETE = 4'd1,
    OP_SEARCH = 4'd2,
    OP_COUNT  = 4'd3,
    OP_LOWER  = 4'd4,
    OP_UPPER  = 4'd5,
    OP_CLOSE  = 4'd6,
    OP_KTH    = 4'd7,
    OP_RANGE  = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] key_value;
    logic signed [31:0] range_high;
    logic [21:0]        rank;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] result_value;
    logic [21:0]        result_count;
    logic [1:0]         status;
  } rsp_t;

endpackage

// ===== rtl/core/omre_ram.sv =====
// Generic simple dual-port synchronous RAM (one write port, one read port) with registered read.
// No dependencies.
module omre_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/ordered_multiset_rank_engine_top.sv =====
// Ordered multiset rank engine: sorted table of distinct keys with counts.
// Sequence: a full scan of the used entries, then for insert or delete a shift pass over
// the moved entries, then the commit state (S_DONE) and the strobe; the worst case is a
// delete of the first entry of a full table. One transaction at a time; the next may start
// in the strobe cycle.
// Result strobe lasts one cycle; the receiver cannot stall.
// Reset clears the entry and occurrence totals; the key/count RAMs are not cleared.
module ordered_multiset_rank_engine_top #(
  parameter int unsigned Capacity  = omre_pkg::DefCapacity,
  parameter int unsigned CountBits = omre_pkg::DefCountBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  omre_pkg::req_t   req_i,
  output logic             busy_o,
  output logic             done_o,
  output omre_pkg::rsp_t   rsp_o
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned UW = $clog2(Capacity + 1);
  localparam int unsigned CW = CountBits;
  localparam int unsigned SW = omre_pkg::TotW + 1;
  localparam logic [omre_pkg::TotW-1:0] TotMax = '1;
  localparam logic [CW-1:0] CntMax = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_INS, S_DEL, S_DONE
  } state_e;

  state_e state_q;
  omre_pkg::req_t req_q;
  logic [UW-1:0] used_q;
  logic [omre_pkg::TotW-1:0] total_q;
  logic [UW-1:0] idx_q;         // address issued this cycle
  logic          rv_q;          // read data valid for idx_q-1
  logic [UW-1:0] pos_q;         // first entry >= key
  logic          pos_ok_q;
  logic          present_q;
  logic [CW-1:0] pcnt_q;
  logic signed [31:0] prev_key_q;
  logic          prev_ok_q;
  logic signed [31:0] ub_q;
  logic          ub_ok_q;
  logic [SW-1:0] acc_q;
  logic          kth_ok_q;
  logic signed [31:0] kth_q;
  logic [UW-1:0] sh_q;          // shift pointer
  logic          sh_rd_q;
  omre_pkg::rsp_t rsp_q;

  // RAM ports
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [31:0]     wkey, rkey;
  logic [CW-1:0]   wcnt, rcnt;

  omre_ram #(.Width(32), .Depth(Capacity)) u_key (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wkey), .raddr_i(raddr), .rdata_o(rkey)
  );
  omre_ram #(.Width(CW), .Depth(Capacity)) u_cnt (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wcnt), .raddr_i(raddr), .rdata_o(rcnt)
  );

  logic signed [31:0] rk;
  logic [UW-1:0] ridx;
  logic [SW-1:0] acc_n;
  logic [SW-1:0] target;
  logic in_rng;
  assign rk     = $signed(rkey);
  assign ridx   = idx_q - UW'(1);
  assign acc_n  = acc_q + SW'(rcnt);
  assign target = SW'(total_q) - SW'(req_q.rank) + SW'(1);
  assign in_rng = (rk >= req_q.key_value) && (rk <= req_q.range_high);

  // closest-value distances in 33 bits
  logic signed [32:0] d_above, d_below;
  assign d_above = 33'(req_q.key_value) - 33'(prev_key_q);

  // final answer assembly from scan results
  omre_pkg::rsp_t fin;
  logic [SW-1:0] rc;
  always_comb begin
    fin = '0;
    d_below = '0;
    rc = '0;
    case (omre_pkg::op_e'(req_q.operation))
      omre_pkg::OP_INSERT: begin
        if (present_q) begin
          fin.found = 1'b1;
          if (pcnt_q == CntMax || total_q == TotMax) begin
            fin.status = omre_pkg::ST_SAT;
          end
        end else if (used_q >= UW'(Capacity)) begin
          fin.status = omre_pkg::ST_FULL;
        end else if (total_q == TotMax) begin
          fin.status = omre_pkg::ST_SAT;
        end else begin
          fin.found = 1'b1;
        end
      end
      omre_pkg::OP_DELETE: fin.found = present_q;
      omre_pkg::OP_SEARCH: fin.found = present_q;
      omre_pkg::OP_COUNT: if (present_q) begin
        fin.found = 1'b1;
        fin.result_count = omre_pkg::TotW'(pcnt_q);
      end
      omre_pkg::OP_LOWER: if (pos_ok_q) begin
        fin.found = 1'b1;
        fin.result_value = ub_q;
      end
      omre_pkg::OP_UPPER: if (ub_ok_q) begin
        fin.found = 1'b1;
        fin.result_value = kth_q;
      end
      omre_pkg::OP_CLOSE: begin
        d_below = 33'(ub_q) - 33'(req_q.key_value);
        if (present_q) begin
          fin.found = 1'b1;
          fin.result_value = req_q.key_value;
        end else if (pos_ok_q && prev_ok_q) begin
          fin.found = 1'b1;
          fin.result_value = (d_below < d_above) ? ub_q : prev_key_q;
        end else if (pos_ok_q) begin
          fin.found = 1'b1;
          fin.result_value = ub_q;
        end else if (prev_ok_q) begin
          fin.found = 1'b1;
          fin.result_value = prev_key_q;
        end
      end
      omre_pkg::OP_KTH: if (kth_ok_q) begin
        fin.found = 1'b1;
        fin.result_value = kth_q;
      end
      omre_pkg::OP_RANGE: if (req_q.key_value <= req_q.range_high) begin
        rc = acc_q;
        fin.found = (acc_q != '0);
        if (rc > SW'(TotMax)) begin
          fin.result_count = TotMax;
          fin.status = omre_pkg::ST_SAT;
        end else begin
          fin.result_count = rc[omre_pkg::TotW-1:0];
        end
      end
      default: ;
    endcase
  end

  // RAM address and write control
  always_comb begin
    we = 1'b0;
    waddr = sh_q[AW-1:0];
    wkey = rkey;
    wcnt = rcnt;
    raddr = idx_q[AW-1:0];
    if (state_q == S_INS) begin
      // move entry sh-1 to sh, then place the key at pos
      raddr = AW'(sh_q - UW'(1));
      if (sh_q == pos_q) begin
        we = 1'b1;
        wkey = req_q.key_value;
        wcnt = CW'(1);
      end else if (sh_rd_q) begin
        we = 1'b1;
      end
    end else if (state_q == S_DEL) begin
      raddr = AW'(sh_q + UW'(1));
      waddr = sh_q[AW-1:0];
      we = sh_rd_q;
    end else if (state_q == S_DONE && req_q.operation == omre_pkg::OP_INSERT
                 && present_q && rsp_q.status != omre_pkg::ST_SAT) begin
      // bump an existing count
      we = 1'b1;
      waddr = pos_q[AW-1:0];
      wkey = req_q.key_value;
      wcnt = pcnt_q + CW'(1);
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q <= '0;
      used_q <= '0;
      total_q <= '0;
      done_o <= 1'b0;
      idx_q <= '0;
      rv_q <= 1'b0;
      pos_q <= '0;
      pos_ok_q <= 1'b0;
      present_q <= 1'b0;
      pcnt_q <= '0;
      prev_ok_q <= 1'b0;
      prev_key_q <= '0;
      ub_ok_q <= 1'b0;
      ub_q <= '0;
      kth_ok_q <= 1'b0;
      kth_q <= '0;
      acc_q <= '0;
      sh_q <= '0;
      sh_rd_q <= 1'b0;
      rsp_q <= '0;
    end else begin
      done_o <= (state_q == S_DONE);
      unique case (state_q)
        S_IDLE: if (start_i) begin
          req_q <= req_i;
          state_q <= S_SCAN;
          idx_q <= '0;
          rv_q <= 1'b0;
          pos_q <= used_q;
          pos_ok_q <= 1'b0;
          present_q <= 1'b0;
          pcnt_q <= '0;
          prev_ok_q <= 1'b0;
          prev_key_q <= '0;
          ub_ok_q <= 1'b0;
          ub_q <= '0;
          kth_ok_q <= 1'b0;
          kth_q <= '0;
          acc_q <= '0;
        end
        S_SCAN: begin
          // consume the entry issued last cycle
          if (rv_q) begin
            if (!pos_ok_q) begin
              if (rk >= req_q.key_value) begin
                pos_ok_q <= 1'b1;
                pos_q <= ridx;
                ub_q <= rk;
                present_q <= (rk == req_q.key_value);
                pcnt_q <= rcnt;
              end else begin
                prev_ok_q <= 1'b1;
                prev_key_q <= rk;
              end
            end
            if (!ub_ok_q && rk > req_q.key_value &&
                req_q.operation == omre_pkg::OP_UPPER) begin
              ub_ok_q <= 1'b1;
              kth_q <= rk;
            end
            if (req_q.operation == omre_pkg::OP_KTH && !kth_ok_q) begin
              acc_q <= acc_n;
              if (req_q.rank != '0 && req_q.rank <= total_q && acc_n >= target) begin
                kth_ok_q <= 1'b1;
                kth_q <= rk;
              end
            end
            if (req_q.operation == omre_pkg::OP_RANGE && in_rng) begin
              acc_q <= acc_n;
            end
          end
          if (idx_q < used_q) begin
            idx_q <= idx_q + UW'(1);
            rv_q <= 1'b1;
          end else begin
            rv_q <= 1'b0;
          end
          // leave scan once the last entry is consumed
          if (!rv_q && (idx_q >= used_q)) begin
            if (req_q.operation == omre_pkg::OP_INSERT && !present_q
                && used_q < UW'(Capacity) && total_q != TotMax) begin
              state_q <= S_INS;
              sh_q <= used_q;
              sh_rd_q <= 1'b0;
            end else if (req_q.operation == omre_pkg::OP_DELETE && present_q) begin
              state_q <= S_DEL;
              sh_q <= pos_q;
              sh_rd_q <= 1'b0;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_INS: begin
          if (sh_q == pos_q) begin
            state_q <= S_DONE;
          end else if (sh_rd_q) begin
            sh_q <= sh_q - UW'(1);
            sh_rd_q <= 1'b0;
          end else begin
            sh_rd_q <= 1'b1;
          end
        end
        S_DEL: begin
          if (sh_q + UW'(1) >= used_q) begin
            state_q <= S_DONE;
          end else if (sh_rd_q) begin
            sh_q <= sh_q + UW'(1);
            sh_rd_q <= 1'b0;
          end else begin
            sh_rd_q <= 1'b1;
          end
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase

      // build the result while the transaction is in flight
      if (state_q != S_DONE && state_q != S_IDLE) begin
        rsp_q <= fin;
      end
      // commit totals
      if (state_q == S_DONE) begin
        if (req_q.operation == omre_pkg::OP_INSERT && rsp_q.status == omre_pkg::ST_OK) begin
          total_q <= total_q + omre_pkg::TotW'(1);
          if (!present_q) begin
            used_q <= used_q + UW'(1);
          end
        end
        if (req_q.operation == omre_pkg::OP_DELETE && present_q) begin
          total_q <= total_q - omre_pkg::TotW'(pcnt_q);
          used_q <= used_q - UW'(1);
        end
      end
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign rsp_o  = rsp_q;

endmodule

// ===== tb/ordered_multiset_rank_engine_checker.sv =====
// Checker for the ordered multiset rank engine: watches the request and result
// channels, predicts every result and compares it. Depends on omre_pkg.
module ordered_multiset_rank_engine_checker #(
  parameter int unsigned Capacity  = omre_pkg::DefCapacity,
  parameter int unsigned CountBits = omre_pkg::DefCountBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  omre_pkg::req_t req_i,
  input  logic           busy_o,
  input  logic           done_o,
  input  omre_pkg::rsp_t rsp_o,
  output int             fail_count_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import omre_pkg::*;

  localparam longint unsigned EntryMax = (64'd1 << CountBits) - 1;
  localparam longint unsigned TotalMax = 64'd4194303;

  // Shadow copy of the sorted multiset
  logic signed [31:0] shadow_key[Capacity];
  longint unsigned    shadow_cnt[Capacity];
  int unsigned        shadow_used;
  longint unsigned    shadow_total;

  rsp_t expected_rsp_q[$];

  initial begin
    fail_count_o = 0;
    shadow_used  = 0;
    shadow_total = 0;
  end

  assign pending_o = expected_rsp_q.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Apply one request to the shadow set and return the answer it gives
  function automatic rsp_t apply_request(req_t r);
    rsp_t               a;
    logic signed [31:0] k;
    logic signed [31:0] hi;
    int unsigned        p;
    int unsigned        q;
    bit                 present;
    longint             above;
    longint             below;
    longint unsigned    acc;
    longint unsigned    target;
    longint unsigned    sum;
    a  = '0;
    k  = r.key_value;
    hi = r.range_high;
    p  = 0;
    while (p < shadow_used && shadow_key[p] < k) p++;
    present = (p < shadow_used) && (shadow_key[p] == k);
    sum = 0;
    case (r.operation)
      OP_INSERT: begin
        if (present) begin
          a.found = 1'b1;
          if (shadow_cnt[p] >= EntryMax || shadow_total >= TotalMax) begin
            a.status = ST_SAT;
          end else begin
            shadow_cnt[p]++;
            shadow_total++;
          end
        end else if (shadow_used >= Capacity) begin
          a.status = ST_FULL;
        end else if (shadow_total >= TotalMax) begin
          a.status = ST_SAT;
        end else begin
          for (int i = shadow_used; i > p; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_cnt[i] = shadow_cnt[i-1];
          end
          shadow_key[p] = k;
          shadow_cnt[p] = 1;
          shadow_used++;
          shadow_total++;
          a.found = 1'b1;
        end
      end
      OP_DELETE: begin
        if (present) begin
          a.found = 1'b1;
          shadow_total -= shadow_cnt[p];
          for (int i = p; i + 1 < shadow_used; i++) begin
            shadow_key[i] = shadow_key[i+1];
            shadow_cnt[i] = shadow_cnt[i+1];
          end
          shadow_used--;
        end
      end
      OP_SEARCH: a.found = present;
      OP_COUNT: begin
        if (present) begin
          a.found = 1'b1;
          sum = shadow_cnt[p];
        end
      end
      OP_LOWER: begin
        if (p < shadow_used) begin
          a.found = 1'b1;
          a.result_value = shadow_key[p];
        end
      end
      OP_UPPER: begin
        q = 0;
        while (q < shadow_used && shadow_key[q] <= k) q++;
        if (q < shadow_used) begin
          a.found = 1'b1;
          a.result_value = shadow_key[q];
        end
      end
      OP_CLOSE: begin
        if (present) begin
          a.found = 1'b1;
          a.result_value = k;
        end else if (p < shadow_used && p > 0) begin
          // wide differences; a tie goes to the smaller neighbor
          above = longint'(shadow_key[p]) - longint'(k);
          below = longint'(k) - longint'(shadow_key[p-1]);
          a.found = 1'b1;
          a.result_value = (above < below) ? shadow_key[p] : shadow_key[p-1];
        end else if (p < shadow_used) begin
          a.found = 1'b1;
          a.result_value = shadow_key[p];
        end else if (p > 0) begin
          a.found = 1'b1;
          a.result_value = shadow_key[p-1];
        end
      end
      OP_KTH: begin
        if (r.rank != 0 && longint'(r.rank) <= shadow_total) begin
          target = shadow_total - r.rank + 1;
          acc = 0;
          for (int i = 0; i < shadow_used; i++) begin
            acc += shadow_cnt[i];
            if (acc >= target && !a.found) begin
              a.found = 1'b1;
              a.result_value = shadow_key[i];
            end
          end
        end
      end
      OP_RANGE: begin
        if (k <= hi) begin
          for (int i = 0; i < shadow_used; i++)
            if (shadow_key[i] >= k && shadow_key[i] <= hi) sum += shadow_cnt[i];
          a.found = (sum != 0);
        end
      end
      default: ;
    endcase
    // clip wide counts
    if (sum > TotalMax) begin
      sum = TotalMax;
      a.status = ST_SAT;
    end
    a.result_count = sum[21:0];
    return a;
  endfunction

  // Predict on each accepted request, compare on each result strobe
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) expected_rsp_q.push_back(apply_request(req_i));
      if (done_o) begin
        if (expected_rsp_q.size() == 0) begin
          $display("[%0t] mismatch: result with no request waiting", $realtime);
          fail_count_o++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_o.found !== want.found)
            report_mismatch("found", rsp_o.found, want.found);
          if (rsp_o.result_value !== want.result_value)
            report_mismatch("result_value", rsp_o.result_value, want.result_value);
          if (rsp_o.result_count !== want.result_count)
            report_mismatch("result_count", rsp_o.result_count, want.result_count);
          if (rsp_o.status !== want.status)
            report_mismatch("status", rsp_o.status, want.status);
        end
      end
    end
  end

endmodule

// ===== tb/ordered_multiset_rank_engine_top_tb.sv =====
// Testbench top for ordered_multiset_rank_engine_top: drives directed and random
// requests and gives the verdict. Depends on omre_pkg and the checker module.
module ordered_multiset_rank_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import omre_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;
  int   fail_count;
  int   pending;
  int   idle_pct;
  int   delete_pct;

  ordered_multiset_rank_engine_top u_top (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .done_o, .rsp_o
  );

  ordered_multiset_rank_engine_checker u_checker (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .done_o, .rsp_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("ordered_multiset_rank_engine_top regression: fail");
    $finish;
  end

  function automatic req_t mk(logic [3:0] op, logic signed [31:0] key, logic signed [31:0] hi,
                              logic [21:0] rank);
    req_t r;
    r.operation  = op;
    r.key_value  = key;
    r.range_high = hi;
    r.rank       = rank;
    return r;
  endfunction

  // Issue one transaction; start stays high after acceptance for back-to-back use
  task automatic send(input req_t r);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Hold off until every expected result has come back
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) return $signed($urandom_range(0, 79)) - 40;
    if (sel < 85) return 32'sh7fffffff;
    if (sel < 90) return 32'sh80000000;
    return $urandom;
  endfunction

  function automatic req_t random_item();
    req_t r;
    int   sel;
    logic signed [31:0] a;
    logic signed [31:0] b;
    sel = $urandom_range(99);
    a = pick_key();
    b = ($urandom_range(3) == 0) ? $signed($urandom) : a + $signed($urandom_range(0, 30));
    r = mk(OP_SEARCH, a, b, ($urandom_range(1) == 0) ? 22'($urandom) :
                            22'($urandom_range(0, 70)));
    if (sel < delete_pct) r.operation = OP_DELETE;
    else if (sel < delete_pct + 35) r.operation = OP_INSERT;
    else if (sel < 97) r.operation = 4'($urandom_range(2, 8));
    else r.operation = 4'($urandom_range(9, 15));
    return r;
  endfunction

  initial begin
    idle_pct   = 0;
    delete_pct = 10;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty set: every query answers not found
    send(mk(OP_SEARCH, 0, 0, 0));
    send(mk(OP_COUNT, 0, 0, 0));
    send(mk(OP_LOWER, 0, 0, 0));
    send(mk(OP_UPPER, 0, 0, 0));
    send(mk(OP_CLOSE, 0, 0, 0));
    send(mk(OP_KTH, 0, 0, 1));
    send(mk(OP_RANGE, 32'sh80000000, 32'sh7fffffff, 0));
    send(mk(OP_DELETE, 5, 0, 0));
    // extremes, zero and a tie for closest
    send(mk(OP_INSERT, 32'sh80000000, 0, 0));
    send(mk(OP_INSERT, 32'sh7fffffff, 0, 0));
    send(mk(OP_INSERT, 5, 0, 0));
    send(mk(OP_INSERT, 7, 0, 0));
    send(mk(OP_INSERT, 7, 0, 0));
    send(mk(OP_CLOSE, 6, 0, 0));
    send(mk(OP_CLOSE, 1000, 0, 0));
    send(mk(OP_INSERT, 0, 0, 0));
    send(mk(OP_CLOSE, 0, 0, 0));
    send(mk(OP_UPPER, 32'sh7fffffff, 0, 0));
    send(mk(OP_KTH, 0, 0, 0));
    send(mk(OP_KTH, 0, 0, 6));
    send(mk(OP_KTH, 0, 0, 7));
    send(mk(OP_KTH, 0, 0, 22'h3fffff));
    send(mk(OP_RANGE, 7, 5, 0));
    send(mk(OP_RANGE, 32'sh80000000, 32'sh7fffffff, 0));
    send(mk(OP_COUNT, 7, 0, 0));
    send(mk(4'd9, 0, 0, 0));
    send(mk(4'd15, -1, -1, 22'h3fffff));

    // fill the table, then two distinct inserts too many
    for (int i = 0; i < 60; i++) send(mk(OP_INSERT, 1000 + i, 0, 0));
    send(mk(OP_INSERT, -1000, 0, 0));
    for (int i = 0; i < 60; i++) send(mk(OP_DELETE, 1000 + i, 0, 0));
    drain();

    // repeat one key many times
    for (int i = 0; i < 20; i++) send(mk(OP_INSERT, 3, 0, 0));
    send(mk(OP_COUNT, 3, 0, 0));
    send(mk(OP_RANGE, 0, 10, 0));
    send(mk(OP_DELETE, 3, 0, 0));
    drain();

    // random phases with varied sender idling
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 55;
        2: idle_pct = 38;
        3: begin idle_pct = 0; delete_pct = 40; end
        default: begin idle_pct = 55; delete_pct = 5; end
      endcase
      for (int n = 0; n < 276; n++) send(random_item());
      if (phase == 2) drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("ordered_multiset_rank_engine_top regression: pass");
    end else begin
      $display("ordered_multiset_rank_engine_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/omre_pkg.sv
rtl/core/omre_ram.sv
rtl/core/ordered_multiset_rank_engine_top.sv
tb/ordered_multiset_rank_engine_checker.sv
tb/ordered_multiset_rank_engine_top_tb.sv
